/* hdl/whp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whp_pkg: shared types and constants of the WAV header parser
// Chunk tags, result and error codes, and the record that travels from the
// parser front end through the queue to the result stage.
// ----------------------------------------------------------------------------
package whp_pkg;

  // Four-character tags, little-endian as they arrive on the byte stream
  localparam logic [31:0] TagData = 32'h6174_6164;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFact = 32'h7463_6166;
  localparam logic [31:0] TagList = 32'h5453_494C;
  localparam logic [31:0] TagBext = 32'h7478_6562;
  localparam logic [31:0] TagJunk = 32'h4B4E_554A;

  localparam logic [15:0] PcmCode    = 16'h0001;
  localparam logic [15:0] Bits8      = 16'd8;
  localparam logic [15:0] Bits16     = 16'd16;
  localparam logic [31:0] FmtMinSize = 32'd16;

  localparam int unsigned WhpQueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_FORMAT = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NOT_RIFF  = 3'd0,
    ERR_NOT_WAVE  = 3'd1,
    ERR_NO_FMT    = 3'd2,
    ERR_NOT_PCM   = 3'd3,
    ERR_BAD_BITS  = 3'd4,
    ERR_NO_DATA   = 3'd5,
    ERR_FMT_SHORT = 3'd6
  } err_e;

  // Classified transaction handed from the front end to the result stage
  typedef struct packed {
    kind_e       kind;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic        wide_sample;
    logic [31:0] data_length;
    logic [7:0]  data_byte;
    err_e        error_code;
    logic        last;
  } whp_op_t;

  function automatic logic skippable(input logic [31:0] tag);
    return (tag == TagFact) || (tag == TagList) || (tag == TagBext) || (tag == TagJunk);
  endfunction

endpackage

/* hdl/whp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whp_if: stream channels of the WAV header parser
// wav_in_if carries file bytes in; wav_out_if carries parse results out.
// ----------------------------------------------------------------------------
interface wav_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_req;

  modport source (output valid, output in_byte, output start_req, input ready);
  modport sink   (input valid, input in_byte, input start_req, output ready);
endinterface

interface wav_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] channels;
  logic [31:0] sample_rate;
  logic        wide_sample;
  logic [31:0] data_length;
  logic [7:0]  data_byte;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, output kind, output channels, output sample_rate,
                  output wide_sample, output data_length, output data_byte,
                  output error_code, output last, input ready);
  modport sink   (input valid, input kind, input channels, input sample_rate,
                  input wide_sample, input data_length, input data_byte,
                  input error_code, input last, output ready);
endinterface

/* hdl/whp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whp_front: byte classifier of the WAV header parser
// Walks the RIFF header, fmt and data chunk headers one byte per cycle while
// the queue has room, pushing format, data-byte and error transactions to it.
// ----------------------------------------------------------------------------
module whp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             start_req_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output whp_pkg::whp_op_t push_op_o
);
  import whp_pkg::*;

  typedef enum logic [3:0] {
    PH_TOP, PH_HDR_FMT, PH_SKIP_FMT, PH_FMT_BODY, PH_FMT_REST,
    PH_HDR_DATA, PH_SKIP_DATA, PH_DATA, PH_IDLE
  } phase_e;

  phase_e      phase_q, phase_d, phase_c;
  logic [3:0]  pos_q, pos_d, pos_c;
  logic [31:0] word_q, word_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] skip_q, skip_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic        wide_q, wide_d;
  logic [31:0] left_q, left_d;
  logic        accept;
  logic        is_fmt;
  logic [31:0] left_dec;
  logic [31:0] skip_dec;

  // Every byte may produce a transaction, so hold off while the queue is full
  assign ready_o = push_ready_i;
  assign accept  = valid_i && push_ready_i;

  always_comb begin
    phase_d      = phase_q;
    pos_d        = pos_q;
    word_d       = word_q;
    tag_d        = tag_q;
    skip_d       = skip_q;
    chan_d       = chan_q;
    rate_d       = rate_q;
    wide_d       = wide_q;
    left_d       = left_q;
    push_valid_o = 1'b0;
    push_op_o    = '0;
    phase_c      = phase_q;
    pos_c        = pos_q;
    is_fmt       = 1'b0;
    left_dec     = '0;
    skip_dec     = '0;

    if (accept) begin
      // A start marker restarts the parse on this very byte
      if (start_req_i) begin
        phase_c = PH_TOP;
        pos_c   = '0;
        word_d  = {in_byte_i, 24'd0};
      end else begin
        phase_c = phase_q;
        pos_c   = pos_q;
        word_d  = {in_byte_i, word_q[31:8]};
      end
      pos_d = pos_c + 4'd1;
      if (start_req_i) begin
        phase_d = PH_TOP;
        tag_d   = '0;
        skip_d  = '0;
        chan_d  = '0;
        rate_d  = '0;
        wide_d  = 1'b0;
        left_d  = '0;
      end

      unique case (phase_c)
        PH_TOP: begin
          if (pos_c == 4'd3 && word_d != TagRiff) begin
            push_valid_o         = 1'b1;
            push_op_o.kind       = KIND_ERROR;
            push_op_o.error_code = ERR_NOT_RIFF;
          end else if (pos_c == 4'd11) begin
            pos_d = '0;
            if (word_d != TagWave) begin
              push_valid_o         = 1'b1;
              push_op_o.kind       = KIND_ERROR;
              push_op_o.error_code = ERR_NOT_WAVE;
            end else begin
              phase_d = PH_HDR_FMT;
            end
          end
        end

        PH_HDR_FMT, PH_HDR_DATA: begin
          is_fmt = (phase_c == PH_HDR_FMT);
          if (pos_c == 4'd3) begin
            tag_d = word_d;
          end
          if (pos_c == 4'd7) begin
            pos_d = '0;
            if (tag_q == (is_fmt ? TagFmt : TagData)) begin
              if (is_fmt) begin
                if (word_d == '0) begin
                  push_valid_o         = 1'b1;
                  push_op_o.kind       = KIND_ERROR;
                  push_op_o.error_code = ERR_NO_FMT;
                end else if (word_d < FmtMinSize) begin
                  push_valid_o         = 1'b1;
                  push_op_o.kind       = KIND_ERROR;
                  push_op_o.error_code = ERR_FMT_SHORT;
                end else begin
                  skip_d  = word_d - FmtMinSize;
                  phase_d = PH_FMT_BODY;
                end
              end else if (word_d == '0) begin
                push_valid_o         = 1'b1;
                push_op_o.kind       = KIND_ERROR;
                push_op_o.error_code = ERR_NO_DATA;
              end else begin
                left_d                = word_d;
                phase_d               = PH_DATA;
                push_valid_o          = 1'b1;
                push_op_o.kind        = KIND_FORMAT;
                push_op_o.channels    = chan_q;
                push_op_o.sample_rate = rate_q;
                push_op_o.wide_sample = wide_q;
                push_op_o.data_length = word_d;
              end
            end else if (!skippable(tag_q)) begin
              push_valid_o         = 1'b1;
              push_op_o.kind       = KIND_ERROR;
              push_op_o.error_code = is_fmt ? ERR_NO_FMT : ERR_NO_DATA;
            end else begin
              skip_d = word_d;
              if (word_d != '0) begin
                phase_d = is_fmt ? PH_SKIP_FMT : PH_SKIP_DATA;
              end else begin
                phase_d = phase_c;
              end
            end
          end
        end

        PH_SKIP_FMT, PH_SKIP_DATA, PH_FMT_REST: begin
          skip_dec = (skip_q != '0) ? skip_q - 32'd1 : skip_q;
          skip_d   = skip_dec;
          pos_d    = pos_c;
          if (skip_dec == '0) begin
            phase_d = (phase_c == PH_SKIP_FMT) ? PH_HDR_FMT : PH_HDR_DATA;
            pos_d   = '0;
          end
        end

        PH_FMT_BODY: begin
          if (pos_c == 4'd1 && word_d[31:16] != PcmCode) begin
            push_valid_o         = 1'b1;
            push_op_o.kind       = KIND_ERROR;
            push_op_o.error_code = ERR_NOT_PCM;
          end else begin
            if (pos_c == 4'd3) begin
              chan_d = word_d[31:16];
            end
            if (pos_c == 4'd7) begin
              rate_d = word_d;
            end
            if (pos_c == 4'd15) begin
              pos_d = '0;
              if (word_d[31:16] == Bits8 || word_d[31:16] == Bits16) begin
                wide_d  = (word_d[31:16] == Bits16);
                phase_d = (skip_q == '0) ? PH_HDR_DATA : PH_FMT_REST;
              end else begin
                push_valid_o         = 1'b1;
                push_op_o.kind       = KIND_ERROR;
                push_op_o.error_code = ERR_BAD_BITS;
              end
            end
          end
        end

        PH_DATA: begin
          left_dec            = (left_q != '0) ? left_q - 32'd1 : left_q;
          left_d              = left_dec;
          pos_d               = pos_c;
          push_valid_o        = 1'b1;
          push_op_o.kind      = KIND_DATA;
          push_op_o.data_byte = in_byte_i;
          push_op_o.last      = (left_dec == '0);
          if (left_dec == '0) begin
            phase_d = PH_IDLE;
          end
        end

        default: begin
          // Idle: drop bytes until the next start marker
          pos_d = pos_c;
        end
      endcase

      // Any error parks the parser until a new stream starts
      if (push_valid_o && push_op_o.kind == KIND_ERROR) begin
        phase_d = PH_IDLE;
        pos_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOP;
      pos_q   <= '0;
      word_q  <= '0;
      tag_q   <= '0;
      skip_q  <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      wide_q  <= 1'b0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      word_q  <= word_d;
      tag_q   <= tag_d;
      skip_q  <= skip_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      wide_q  <= wide_d;
      left_q  <= left_d;
    end
  end

endmodule

/* hdl/whp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whp_queue: transaction queue between parser front end and result stage
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module whp_queue #(
  parameter int unsigned Depth = whp_pkg::WhpQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  whp_pkg::whp_op_t push_op_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output whp_pkg::whp_op_t pop_op_o
);
  import whp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  whp_op_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_op_o     = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_op_i;
    end
  end

endmodule

/* hdl/whp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whp_back: result stage of the WAV header parser
// Pops transactions, clears the fields that do not belong to each result
// kind and holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module whp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  whp_pkg::whp_op_t pop_op_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output whp_pkg::whp_op_t out_op_o
);
  import whp_pkg::*;

  logic    valid_q, valid_d;
  whp_op_t res_q, res_d;
  logic    load;

  assign pop_ready_o = !valid_q || out_ready_i;
  assign load        = pop_valid_i && pop_ready_o;
  assign out_valid_o = valid_q;
  assign out_op_o    = res_q;

  always_comb begin
    res_d      = '0;
    res_d.kind = pop_op_i.kind;
    case (pop_op_i.kind)
      KIND_FORMAT: begin
        res_d.channels    = pop_op_i.channels;
        res_d.sample_rate = pop_op_i.sample_rate;
        res_d.wide_sample = pop_op_i.wide_sample;
        res_d.data_length = pop_op_i.data_length;
      end
      KIND_DATA: begin
        res_d.data_byte = pop_op_i.data_byte;
        res_d.last      = pop_op_i.last;
      end
      default: begin
        res_d.error_code = pop_op_i.error_code;
      end
    endcase
    valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

endmodule

/* hdl/wav_header_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_header_parser: streaming RIFF/WAVE header parser
// Checks the RIFF/WAVE header, captures the PCM format and forwards the
// data chunk byte by byte.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one file byte per transaction; start_req marks the first
//         byte of a new file and restarts the parse on that byte.
//   out_o carries one format result when the data chunk header is complete,
//         one result per data byte (last set on the final one), or one error
//         result, after which bytes are dropped until the next start marker.
//   Throughput: one byte per cycle while the queue is not full; the front end
//   decodes a byte in the cycle it is accepted.
//   Path: a result passes through a queue entry, then the output register,
//   before it is valid on out_o.
//   Stall: the output register holds while out_o.ready is low, the queue
//   takes QUEUE_DEPTH more transactions, and in_i.ready is low while the
//   queue is full. Reset: the parser expects the RIFF word; queue and
//   output are empty, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module wav_header_parser #(
  parameter int unsigned QUEUE_DEPTH = whp_pkg::WhpQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  wav_in_if.sink    in_i,
  wav_out_if.source out_o
);
  import whp_pkg::*;

  logic    push_valid, push_ready;
  whp_op_t push_op;
  logic    pop_valid, pop_ready;
  whp_op_t pop_op;
  whp_op_t res;

  whp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_i.valid),
    .ready_o      (in_i.ready),
    .in_byte_i    (in_i.in_byte),
    .start_req_i  (in_i.start_req),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  whp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  whp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_op_i    (pop_op),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_op_o    (res)
  );

  assign out_o.kind        = res.kind;
  assign out_o.channels    = res.channels;
  assign out_o.sample_rate = res.sample_rate;
  assign out_o.wide_sample = res.wide_sample;
  assign out_o.data_length = res.data_length;
  assign out_o.data_byte   = res.data_byte;
  assign out_o.error_code  = res.error_code;
  assign out_o.last        = res.last;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the WAV header parser
// Feeds whole WAV files, broken files and stray bytes into the byte channel,
// predicts every format, data and error result in a parser of its own, and
// checks each result field by field. The sender and the receiver idle at
// random in several phases, and the receiver once holds off long enough to
// back up the block.
// ----------------------------------------------------------------------------
module testbench;
  import whp_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned PhaseBytes  = 240;

  typedef enum logic [3:0] {
    PS_RIFF, PS_FMT_HDR, PS_FMT_SKIP, PS_FMT_BODY, PS_FMT_REST,
    PS_DATA_HDR, PS_DATA_SKIP, PS_DATA, PS_IDLE
  } parse_state_e;

  typedef struct packed {
    logic [7:0] value;
    logic       sop;
  } file_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic rx_hold = 1'b0;
  logic hold_armed = 1'b0;

  wav_in_if  in_ch ();
  wav_out_if out_ch ();

  wav_header_parser uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #5 clk_i = ~clk_i;

  file_byte_t  stream_bytes[$];
  whp_op_t     predicted_results[$];
  file_byte_t  next_byte;
  whp_op_t     predicted;
  whp_op_t     want;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_pushed = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Parser state of the predictor
  parse_state_e ps;
  logic [3:0]   pos;
  logic [31:0]  shift_word;
  logic [31:0]  tag_word;
  logic [31:0]  skip_cnt;
  logic [15:0]  chan_q;
  logic [31:0]  rate_q;
  logic         wide_q;
  logic [31:0]  data_cnt;

  function automatic void parser_reset();
    ps         = PS_RIFF;
    pos        = '0;
    shift_word = '0;
    tag_word   = '0;
    skip_cnt   = '0;
    chan_q     = '0;
    rate_q     = '0;
    wide_q     = 1'b0;
    data_cnt   = '0;
  endfunction

  function automatic bit raise_error(input err_e code, output whp_op_t res);
    res            = '0;
    res.kind       = KIND_ERROR;
    res.error_code = code;
    ps             = PS_IDLE;
    pos            = '0;
    return 1'b1;
  endfunction

  // Advance the parse by one byte; return 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] b, input logic sop,
                                    output whp_op_t res);
    logic [31:0] size;
    logic [15:0] bits;
    res = '0;
    if (sop) parser_reset();
    shift_word = {b, shift_word[31:8]};
    case (ps)
      PS_RIFF: begin
        if (pos == 4'd3 && shift_word != TagRiff) return raise_error(ERR_NOT_RIFF, res);
        if (pos == 4'd11) begin
          if (shift_word != TagWave) return raise_error(ERR_NOT_WAVE, res);
          ps  = PS_FMT_HDR;
          pos = '0;
        end else begin
          pos = pos + 4'd1;
        end
      end
      PS_FMT_HDR, PS_DATA_HDR: begin
        if (pos == 4'd3) tag_word = shift_word;
        if (pos < 4'd7) begin
          pos = pos + 4'd1;
        end else begin
          size = shift_word;
          pos  = '0;
          if (ps == PS_FMT_HDR && tag_word == TagFmt) begin
            if (size == 0) return raise_error(ERR_NO_FMT, res);
            if (size < FmtMinSize) return raise_error(ERR_FMT_SHORT, res);
            skip_cnt = size - FmtMinSize;
            ps       = PS_FMT_BODY;
          end else if (ps == PS_DATA_HDR && tag_word == TagData) begin
            if (size == 0) return raise_error(ERR_NO_DATA, res);
            data_cnt        = size;
            ps              = PS_DATA;
            res.kind        = KIND_FORMAT;
            res.channels    = chan_q;
            res.sample_rate = rate_q;
            res.wide_sample = wide_q;
            res.data_length = size;
            return 1'b1;
          end else if (tag_word != TagFact && tag_word != TagList &&
                       tag_word != TagBext && tag_word != TagJunk) begin
            return raise_error((ps == PS_FMT_HDR) ? ERR_NO_FMT : ERR_NO_DATA, res);
          end else begin
            skip_cnt = size;
            if (size != 0) ps = (ps == PS_FMT_HDR) ? PS_FMT_SKIP : PS_DATA_SKIP;
          end
        end
      end
      PS_FMT_SKIP, PS_DATA_SKIP, PS_FMT_REST: begin
        if (skip_cnt != 0) skip_cnt = skip_cnt - 1;
        if (skip_cnt == 0) begin
          ps  = (ps == PS_FMT_SKIP) ? PS_FMT_HDR : PS_DATA_HDR;
          pos = '0;
        end
      end
      PS_FMT_BODY: begin
        if (pos == 4'd1 && shift_word[31:16] != PcmCode) return raise_error(ERR_NOT_PCM, res);
        if (pos == 4'd3) chan_q = shift_word[31:16];
        if (pos == 4'd7) rate_q = shift_word;
        if (pos == 4'd15) begin
          bits = shift_word[31:16];
          if (bits == Bits8) wide_q = 1'b0;
          else if (bits == Bits16) wide_q = 1'b1;
          else return raise_error(ERR_BAD_BITS, res);
          pos = '0;
          ps  = (skip_cnt == 0) ? PS_DATA_HDR : PS_FMT_REST;
        end else begin
          pos = pos + 4'd1;
        end
      end
      PS_DATA: begin
        if (data_cnt != 0) data_cnt = data_cnt - 1;
        res.kind      = KIND_DATA;
        res.data_byte = b;
        res.last      = (data_cnt == 0);
        if (data_cnt == 0) ps = PS_IDLE;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
    return 1'b0;
  endfunction

  task automatic push_byte(input logic [7:0] value, input logic sop);
    stream_bytes.push_back('{value: value, sop: sop});
    bytes_pushed++;
  endtask

  task automatic push_word(input logic [31:0] w, input int unsigned n);
    for (int i = 0; i < n; i++) push_byte(w[8*i +: 8], 1'b0);
  endtask

  task automatic push_skip_chunks(input int unsigned n, input int unsigned max_size);
    logic [31:0] tag;
    int unsigned size;
    repeat (n) begin
      case ($urandom_range(3))
        0:       tag = TagFact;
        1:       tag = TagList;
        2:       tag = TagBext;
        default: tag = TagJunk;
      endcase
      size = $urandom_range(max_size);
      push_word(tag, 4);
      push_word(size, 4);
      repeat (size) push_byte(8'($urandom), 1'b0);
    end
  endtask

  // Emit one file; the first byte carries the start marker
  task automatic push_file(input logic [31:0] riff, wave, input int unsigned n_pre,
                           input logic [31:0] fmt_tag, fmt_size,
                           input logic [15:0] enc, chans, input logic [31:0] rate,
                           input logic [15:0] bits, input int unsigned n_mid,
                           input int unsigned skip_max, input logic [31:0] data_tag,
                           data_size, input int unsigned n_data);
    logic [15:0] align;
    align = 16'($urandom);
    push_byte(riff[7:0], 1'b1);
    push_word(riff >> 8, 3);
    push_word($urandom, 4);
    push_word(wave, 4);
    push_skip_chunks(n_pre, skip_max);
    push_word(fmt_tag, 4);
    push_word(fmt_size, 4);
    push_word({chans, enc}, 4);
    push_word(rate, 4);
    push_word($urandom, 4);
    push_word({bits, align}, 4);
    if (fmt_size > FmtMinSize && fmt_size < 64)
      repeat (fmt_size - FmtMinSize) push_byte(8'($urandom), 1'b0);
    push_skip_chunks(n_mid, skip_max);
    push_word(data_tag, 4);
    push_word(data_size, 4);
    repeat (n_data) push_byte(8'($urandom), 1'b0);
  endtask

  task automatic push_random_file();
    logic [31:0] riff, wave, fmt_tag, fmt_size, rate, data_tag, data_size;
    logic [15:0] enc, chans, bits;
    int unsigned sel, n_data;
    riff     = ($urandom_range(99) < 3) ? $urandom : TagRiff;
    wave     = ($urandom_range(99) < 3) ? $urandom : TagWave;
    fmt_tag  = ($urandom_range(99) < 3) ? $urandom : TagFmt;
    sel      = $urandom_range(99);
    fmt_size = (sel < 4) ? 0 : (sel < 10) ? $urandom_range(1, 15) : $urandom_range(16, 22);
    enc      = ($urandom_range(99) < 4) ? 16'($urandom) : PcmCode;
    sel      = $urandom_range(9);
    chans    = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom);
    sel      = $urandom_range(9);
    rate     = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
    sel      = $urandom_range(99);
    bits     = (sel < 45) ? Bits8 : (sel < 90) ? Bits16 : 16'($urandom_range(40));
    data_tag = ($urandom_range(99) < 3) ? $urandom : TagData;
    sel      = $urandom_range(99);
    data_size = (sel < 3) ? 0 : (sel < 6) ? $urandom : $urandom_range(1, 24);
    if (data_size > 24) n_data = $urandom_range(10);
    else if ($urandom_range(99) < 10) n_data = $urandom_range(data_size);
    else n_data = data_size;
    push_file(riff, wave, $urandom_range(2), fmt_tag, fmt_size, enc, chans, rate, bits,
              $urandom_range(2), 6, data_tag, data_size, n_data);
    // Stray bytes, now and then with a start marker among them
    if ($urandom_range(99) < 15)
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom), $urandom_range(99) < 20);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (mismatch_count < 40)
      $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
               results_checked, what, got, exp_val);
    mismatch_count++;
  endtask

  // Byte driver: predict on each accepted transaction, then offer the next byte
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        if (parse_byte(in_ch.in_byte, in_ch.start_req, predicted))
          predicted_results.push_back(predicted);
        bytes_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = stream_bytes.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.in_byte   <= next_byte.value;
          in_ch.start_req <= next_byte.sop;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result, kind", out_ch.kind, 0);
        end else begin
          want = predicted_results.pop_front();
          if (out_ch.kind != want.kind) report_mismatch("kind", out_ch.kind, want.kind);
          if (out_ch.channels != want.channels)
            report_mismatch("channels", out_ch.channels, want.channels);
          if (out_ch.sample_rate != want.sample_rate)
            report_mismatch("sample_rate", out_ch.sample_rate, want.sample_rate);
          if (out_ch.wide_sample != want.wide_sample)
            report_mismatch("wide_sample", out_ch.wide_sample, want.wide_sample);
          if (out_ch.data_length != want.data_length)
            report_mismatch("data_length", out_ch.data_length, want.data_length);
          if (out_ch.data_byte != want.data_byte)
            report_mismatch("data_byte", out_ch.data_byte, want.data_byte);
          if (out_ch.error_code != want.error_code)
            report_mismatch("error_code", out_ch.error_code, want.error_code);
          if (out_ch.last != want.last) report_mismatch("last", out_ch.last, want.last);
        end
        results_checked++;
      end
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off while the sender keeps offering bytes
  initial begin
    wait (hold_armed);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned target;
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = '0;
    in_ch.start_req = 1'b0;
    out_ch.ready    = 1'b0;
    parser_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Header checks, each failing on its own
    push_file(32'h4646_4953, TagWave, 0, TagFmt, 16, PcmCode, 1, 8000, Bits8, 0, 6,
              TagData, 2, 2);
    push_file(TagRiff, 32'h4556_4158, 0, TagFmt, 16, PcmCode, 1, 8000, Bits8, 0, 6,
              TagData, 2, 2);
    push_file(TagRiff, TagWave, 1, TagData, 16, PcmCode, 1, 8000, Bits8, 0, 6,
              TagData, 2, 2);
    push_file(TagRiff, TagWave, 0, TagFmt, 0, PcmCode, 1, 8000, Bits8, 0, 6,
              TagData, 2, 2);
    push_file(TagRiff, TagWave, 0, TagFmt, 15, PcmCode, 1, 8000, Bits8, 0, 6,
              TagData, 2, 2);
    push_file(TagRiff, TagWave, 0, TagFmt, 1, PcmCode, 1, 8000, Bits8, 0, 6,
              TagData, 2, 2);
    push_file(TagRiff, TagWave, 0, TagFmt, 16, 16'h0003, 1, 8000, Bits8, 0, 6,
              TagData, 2, 2);
    push_file(TagRiff, TagWave, 0, TagFmt, 16, PcmCode, 1, 8000, 16'd24, 0, 6,
              TagData, 2, 2);
    push_file(TagRiff, TagWave, 0, TagFmt, 16, PcmCode, 1, 8000, Bits8, 1, 6,
              TagFmt, 2, 2);
    push_file(TagRiff, TagWave, 0, TagFmt, 16, PcmCode, 1, 8000, Bits8, 0, 6,
              TagData, 0, 2);
    // Complete files: field extremes, fmt tail, empty skipped chunks
    push_file(TagRiff, TagWave, 2, TagFmt, 18, PcmCode, 16'hFFFF, 32'hFFFF_FFFF, Bits16,
              2, 6, TagData, 3, 3);
    push_word($urandom, 2);
    push_file(TagRiff, TagWave, 1, TagFmt, 16, PcmCode, 16'h0000, 32'h0, Bits8, 1, 0,
              TagData, 32'hFFFF_FFFF, 5);
    // Restart in the middle of a data chunk, then a cut-off RIFF header
    push_word(TagRiff, 4);
    stream_bytes[stream_bytes.size() - 4].sop = 1'b1;
    push_word($urandom, 2);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      target = bytes_pushed + PhaseBytes;
      while (bytes_pushed < target) push_random_file();
      if (p == 0) hold_armed = 1'b1;
      while (bytes_taken < bytes_pushed) @(posedge clk_i);
    end

    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* wav_header_parser.f */
hdl/whp_pkg.sv
hdl/whp_if.sv
hdl/whp_front.sv
hdl/whp_queue.sv
hdl/whp_back.sv
hdl/wav_header_parser.sv
sim/testbench.sv
